/* design/mvt_pkg.sv */
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants for the 4x4 matrix-vector transform
// Lane and accumulator types, the beat that travels along the cell chain,
// register indexes and the identity reset values of the matrix columns.
// ----------------------------------------------------------------------------
`default_nettype none

package mvt_pkg;

  // Number of vector lanes and matrix columns.
  localparam int unsigned LANES = 4;
  // Width of one Q8.8 element.
  localparam int unsigned LANE_W = 16;
  // Width of one packed matrix column.
  localparam int unsigned COL_W = LANES * LANE_W;
  // Accumulator width: four Q16.16 products need 34 signed bits; one spare.
  localparam int unsigned ACC_W = 35;
  // Fraction bits dropped by the final shift.
  localparam int unsigned FRAC_BITS = 8;

  typedef logic signed [LANE_W-1:0] lane_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [COL_W-1:0]         col_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_COL0 = 2'd0,
    REG_COL1 = 2'd1,
    REG_COL2 = 2'd2,
    REG_COL3 = 2'd3
  } reg_idx_t;

  // Identity matrix, one column per register.
  localparam col_t COL0_RESET = 64'h0000_0000_0000_0100;
  localparam col_t COL1_RESET = 64'h0000_0000_0100_0000;
  localparam col_t COL2_RESET = 64'h0000_0100_0000_0000;
  localparam col_t COL3_RESET = 64'h0100_0000_0000_0000;

  // One beat moving between neighboring cells: the vector lanes still to be
  // consumed (lane 0 is used next) and the four running sums.
  typedef struct packed {
    logic                    valid;
    logic [LANES-1:0][LANE_W-1:0] vec;
    logic [LANES-1:0][ACC_W-1:0]  acc;
  } link_t;

endpackage

`default_nettype wire

/* design/mvt_in_if.sv */
// ----------------------------------------------------------------------------
// mvt_in_if: input vector channel
// Valid/ready channel carrying one four-element Q8.8 vector per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mvt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vec_x;
  logic signed [15:0] vec_y;
  logic signed [15:0] vec_z;
  logic signed [15:0] vec_w;

  modport source (output valid, output vec_x, output vec_y, output vec_z,
                  output vec_w, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z,
                  input vec_w, output ready);
endinterface

`default_nettype wire

/* design/mvt_out_if.sv */
// ----------------------------------------------------------------------------
// mvt_out_if: result vector channel
// Valid/ready channel carrying one saturated Q8.8 result and its overflow
// flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mvt_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic signed [15:0] out_w;
  logic               overflow;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output out_w, output overflow, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input out_w, input overflow, output ready);
endinterface

`default_nettype wire

/* design/mvt_cell.sv */
// ----------------------------------------------------------------------------
// mvt_cell: one multiply-accumulate cell of the chain
// Multiplies vector lane 0 by the four elements of its matrix column, adds
// the products to the running sums and hands the beat to the next cell with
// the vector shifted down by one lane.
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire mvt_pkg::col_t col_i,
  input  wire mvt_pkg::link_t link_i,
  output mvt_pkg::link_t     link_o
);

  logic                                          valid_r;
  logic [mvt_pkg::LANES-1:0][mvt_pkg::LANE_W-1:0] vec_r, vec_nxt;
  logic [mvt_pkg::LANES-1:0][mvt_pkg::ACC_W-1:0]  acc_r, acc_nxt;

  // Products of this column with the current lane, added to the partial sums.
  always_comb begin
    logic signed [2*mvt_pkg::LANE_W-1:0] prod;
    for (int i = 0; i < mvt_pkg::LANES; i++) begin
      prod = $signed(col_i[i*mvt_pkg::LANE_W +: mvt_pkg::LANE_W]) *
             $signed(link_i.vec[0]);
      acc_nxt[i] = $signed(link_i.acc[i]) +
                   $signed({{(mvt_pkg::ACC_W-2*mvt_pkg::LANE_W){prod[2*mvt_pkg::LANE_W-1]}},
                            prod});
    end
    for (int i = 0; i < mvt_pkg::LANES - 1; i++) begin
      vec_nxt[i] = link_i.vec[i+1];
    end
    vec_nxt[mvt_pkg::LANES-1] = '0;
  end

  // Beat valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= link_i.valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      vec_r <= vec_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign link_o.valid = valid_r;
  assign link_o.vec   = vec_r;
  assign link_o.acc   = acc_r;

endmodule

`default_nettype wire

/* design/mvt_sat.sv */
// ----------------------------------------------------------------------------
// mvt_sat: scaling, saturation and output register
// Drops the fraction bits of each finished sum with an arithmetic shift,
// clamps it to 16 signed bits and holds the result beat for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_sat (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire mvt_pkg::link_t link_i,
  output logic                valid_o,
  output mvt_pkg::lane_t      res_o [mvt_pkg::LANES],
  output logic                ovf_o
);

  // Bits of the sum that must all equal the sign for the shifted value to fit.
  localparam int unsigned TOP_LO = mvt_pkg::FRAC_BITS + mvt_pkg::LANE_W - 1;

  logic           valid_r;
  mvt_pkg::lane_t res_r [mvt_pkg::LANES];
  mvt_pkg::lane_t res_nxt [mvt_pkg::LANES];
  logic           ovf_r, ovf_nxt;

  // Shift right by the fraction width and clamp each lane.
  always_comb begin
    logic [mvt_pkg::ACC_W-TOP_LO-1:0] top;
    logic                             sgn;
    ovf_nxt = 1'b0;
    for (int i = 0; i < mvt_pkg::LANES; i++) begin
      top = link_i.acc[i][mvt_pkg::ACC_W-1:TOP_LO];
      sgn = link_i.acc[i][mvt_pkg::ACC_W-1];
      if ((top == '0) || (top == '1)) begin
        res_nxt[i] = link_i.acc[i][TOP_LO:mvt_pkg::FRAC_BITS];
      end else begin
        res_nxt[i] = sgn ? {1'b1, {(mvt_pkg::LANE_W-1){1'b0}}}
                         : {1'b0, {(mvt_pkg::LANE_W-1){1'b1}}};
        ovf_nxt    = 1'b1;
      end
    end
  end

  // Output beat valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= link_i.valid;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign valid_o = valid_r;
  assign res_o   = res_r;
  assign ovf_o   = ovf_r;

endmodule

`default_nettype wire

/* design/matrix4_vector_transform.sv */
// ----------------------------------------------------------------------------
// matrix4_vector_transform: streaming 4x4 matrix times vector, signed Q8.8
// Result element i is the sum over k of column k element i times v[k],
// shifted right by 8 and saturated, with a flag for any clamped element.
// ----------------------------------------------------------------------------
// A vector enters a chain of four multiply-accumulate cells, one per matrix
// column, and then a saturation stage that is also the output register. The
// block takes one vector per clock cycle unless the chain is held, and each
// vector passes through the five pipeline registers of the chain, the four
// cells and then the saturation stage. When the sink holds off, the whole
// chain holds and in_ch.ready drops, so up to five vectors are in flight.
// The matrix resets to identity and is loaded one column per write on the
// cfg port; columns are read directly by the cells, so write them only
// while the chain is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4_vector_transform (
  input  wire logic       clk,
  input  wire logic       rst_n,
  mvt_in_if.sink          in_ch,
  mvt_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  mvt_pkg::col_t  col_r [mvt_pkg::LANES];
  mvt_pkg::link_t link [mvt_pkg::LANES+1];
  mvt_pkg::lane_t res [mvt_pkg::LANES];
  logic           adv;
  logic           out_valid;
  logic           ovf;
  logic [mvt_pkg::LANES-1:0] cell_valid;

  // The chain moves whenever the output register is free or being emptied.
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Matrix column registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r[0] <= mvt_pkg::COL0_RESET;
      col_r[1] <= mvt_pkg::COL1_RESET;
      col_r[2] <= mvt_pkg::COL2_RESET;
      col_r[3] <= mvt_pkg::COL3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mvt_pkg::REG_COL0: col_r[0] <= cfg_wdata;
        mvt_pkg::REG_COL1: col_r[1] <= cfg_wdata;
        mvt_pkg::REG_COL2: col_r[2] <= cfg_wdata;
        mvt_pkg::REG_COL3: col_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input beat feeds the head of the chain with cleared sums.
  assign link[0].valid  = in_ch.valid;
  assign link[0].vec[0] = in_ch.vec_x;
  assign link[0].vec[1] = in_ch.vec_y;
  assign link[0].vec[2] = in_ch.vec_z;
  assign link[0].vec[3] = in_ch.vec_w;
  assign link[0].acc    = '0;

  // One cell per matrix column.
  for (genvar k = 0; k < mvt_pkg::LANES; k++) begin : g_cell
    mvt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .col_i  (col_r[k]),
      .link_i (link[k]),
      .link_o (link[k+1])
    );
    assign cell_valid[k] = link[k+1].valid;
  end

  // Scaling, saturation and output register.
  mvt_sat u_sat (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .link_i  (link[mvt_pkg::LANES]),
    .valid_o (out_valid),
    .res_o   (res),
    .ovf_o   (ovf)
  );

  assign out_ch.valid    = out_valid;
  assign out_ch.out_x    = res[0];
  assign out_ch.out_y    = res[1];
  assign out_ch.out_z    = res[2];
  assign out_ch.out_w    = res[3];
  assign out_ch.overflow = ovf;

`ifndef SYNTHESIS
  // An accepted vector occupies the first cell on the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> link[1].valid)
    else $error("accepted vector did not enter the first cell");

  // A stalled output freezes every cell of the chain.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(cell_valid))
    else $error("chain moved while the output was stalled");

  // The last cell's beat reaches the output register when the chain moves.
  a_tail_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (link[mvt_pkg::LANES].valid && adv) |=> out_ch.valid)
    else $error("beat lost between last cell and output");

  // Overflow is only reported together with a clamped element.
  a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.overflow) |->
      (out_ch.out_x == 16'h7FFF || out_ch.out_x == 16'h8000 ||
       out_ch.out_y == 16'h7FFF || out_ch.out_y == 16'h8000 ||
       out_ch.out_z == 16'h7FFF || out_ch.out_z == 16'h8000 ||
       out_ch.out_w == 16'h7FFF || out_ch.out_w == 16'h8000))
    else $error("overflow flagged without a saturated element");
`endif

endmodule

`default_nettype wire
